/* design/bthe_pkg.sv */
// Shared types and constants for the BER tag and length header encoder.
`timescale 1ns / 1ps
package bthe_pkg;

   localparam int FIELD_W          = 31;
   localparam int TAG_BITS_DEFAULT = 31;
   localparam int LEN_BITS_DEFAULT = 31;
   localparam int IDX_W            = 3;
   localparam int HLEN_W           = 4;

   localparam logic [FIELD_W-1:0] MAX_TAG_RESET = 31'h7FFF_FFFF;
   localparam int LOW_TAG_LIMIT    = 31;
   localparam int SHORT_LEN_LIMIT  = 128;
   localparam logic [4:0] ID_ESCAPE = 5'h1F;
   localparam logic [7:0] MORE_BIT  = 8'h80;
   localparam logic [7:0] LONG_LEN  = 8'h80;

   typedef struct packed {
      logic [1:0]         tag_class;
      logic               constructed;
      logic [FIELD_W-1:0] tag_number;
      logic [FIELD_W-1:0] content_length;
   } req_type;

   typedef struct packed {
      logic [7:0]        header_octet;
      logic              last_octet;
      logic              status;
      logic [HLEN_W-1:0] header_length;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_ERR,
      ST_ID_LEAD,
      ST_TAG,
      ST_LEN_LEAD,
      ST_LEN
   } state_type;

   typedef enum logic [2:0] {
      OCT_ERR,
      OCT_ID_LEAD,
      OCT_TAG,
      OCT_LEN_LEAD,
      OCT_LEN
   } octet_sel_type;

   typedef struct packed {
      logic          load;
      logic          prep;
      logic          emit;
      logic          last;
      octet_sel_type sel;
      logic          idx_load_tag;
      logic          idx_load_len;
      logic          idx_dec;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic tag_small;
      logic len_short;
      logic idx_zero;
   } sts_type;

endpackage

/* design/bthe_datapath.sv */
// Datapath: request registers, digit counting, octet selection and result register.
`timescale 1ns / 1ps
module bthe_datapath #(
   parameter int TAG_BITS = bthe_pkg::TAG_BITS_DEFAULT,
   parameter int LEN_BITS = bthe_pkg::LEN_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bthe_pkg::req_type             req_payload,
   input  logic                          csr_valid,
   input  logic [bthe_pkg::FIELD_W-1:0]  csr_data,
   input  bthe_pkg::cmd_type             cmd,
   output bthe_pkg::sts_type             sts,
   output logic                          rsp_strobe,
   output bthe_pkg::rsp_type             rsp_payload
);
   import bthe_pkg::*;

   localparam int NG     = (TAG_BITS + 6) / 7;
   localparam int NB     = (LEN_BITS + 7) / 8;
   localparam int TPAD_W = NG * 7;
   localparam int LPAD_W = NB * 8;

   logic [1:0]          cls_ff, cls_in;
   logic                cons_ff, cons_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [FIELD_W-1:0]  max_ff, max_in;
   logic [IDX_W-1:0]    tdig_ff, tdig_in;
   logic [IDX_W-1:0]    lbyt_ff, lbyt_in;
   logic [HLEN_W-1:0]   hlen_ff, hlen_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   rsp_type             rsp_ff, rsp_in;
   logic                strobe_ff, strobe_in;

   logic [TPAD_W-1:0]   tag_pad;
   logic [LPAD_W-1:0]   len_pad;
   logic [IDX_W-1:0]    tdig_calc, lbyt_calc;
   logic [HLEN_W-1:0]   id_cnt, len_cnt;
   logic [6:0]          digit;
   logic [7:0]          len_byte;
   logic [7:0]          lead;
   logic [7:0]          octet;
   logic                tag_small, len_short;

   assign tag_pad   = TPAD_W'(tag_ff);
   assign len_pad   = LPAD_W'(len_ff);
   assign tag_small = tag_ff < TAG_BITS'(LOW_TAG_LIMIT);
   assign len_short = len_ff < LEN_BITS'(SHORT_LEN_LIMIT);

   // count base-128 tag digits and big-endian length bytes
   always_comb begin
      tdig_calc = IDX_W'(1);
      for (int g = 0; g < NG; g++) begin
         if (tag_pad[g*7 +: 7] != 7'd0) begin
            tdig_calc = IDX_W'(g + 1);
         end
      end
      lbyt_calc = '0;
      for (int b = 0; b < NB; b++) begin
         if (len_pad[b*8 +: 8] != 8'd0) begin
            lbyt_calc = IDX_W'(b + 1);
         end
      end
      id_cnt  = HLEN_W'(1) + (tag_small ? HLEN_W'(0) : HLEN_W'(tdig_calc));
      len_cnt = HLEN_W'(1) + (len_short ? HLEN_W'(0) : HLEN_W'(lbyt_calc));
   end

   always_comb begin
      digit    = '0;
      len_byte = '0;
      for (int g = 0; g < NG; g++) begin
         if (idx_ff == IDX_W'(g)) begin
            digit = tag_pad[g*7 +: 7];
         end
      end
      for (int b = 0; b < NB; b++) begin
         if (idx_ff == IDX_W'(b)) begin
            len_byte = len_pad[b*8 +: 8];
         end
      end
   end

   assign lead = {cls_ff, cons_ff, 5'd0};

   always_comb begin
      case (cmd.sel)
         OCT_ID_LEAD:  octet = lead | {3'd0, (tag_small ? tag_ff[4:0] : ID_ESCAPE)};
         OCT_TAG:      octet = {1'b0, digit} | ((idx_ff != '0) ? MORE_BIT : 8'd0);
         OCT_LEN_LEAD: octet = len_short ? 8'(len_ff[6:0]) : (LONG_LEN | 8'(lbyt_ff));
         OCT_LEN:      octet = len_byte;
         default:      octet = 8'd0;
      endcase
   end

   always_comb begin
      cls_in    = cmd.load ? req_payload.tag_class   : cls_ff;
      cons_in   = cmd.load ? req_payload.constructed : cons_ff;
      tag_in    = cmd.load ? req_payload.tag_number[TAG_BITS-1:0]     : tag_ff;
      len_in    = cmd.load ? req_payload.content_length[LEN_BITS-1:0] : len_ff;
      max_in    = csr_valid ? csr_data : max_ff;
      tdig_in   = cmd.prep ? tdig_calc : tdig_ff;
      lbyt_in   = cmd.prep ? lbyt_calc : lbyt_ff;
      hlen_in   = cmd.prep ? HLEN_W'(id_cnt + len_cnt) : hlen_ff;
      idx_in    = idx_ff;
      if (cmd.idx_load_tag) begin
         idx_in = tdig_ff - IDX_W'(1);
      end else if (cmd.idx_load_len) begin
         idx_in = lbyt_ff - IDX_W'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - IDX_W'(1);
      end
      rsp_in = rsp_ff;
      if (cmd.emit) begin
         rsp_in.header_octet  = octet;
         rsp_in.last_octet    = cmd.last;
         rsp_in.status        = (cmd.sel == OCT_ERR);
         rsp_in.header_length = (cmd.sel == OCT_ERR) ? HLEN_W'(0) : hlen_ff;
      end
      strobe_in = cmd.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= MAX_TAG_RESET;
         strobe_ff <= 1'b0;
      end else begin
         max_ff    <= max_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff  <= cls_in;
      cons_ff <= cons_in;
      tag_ff  <= tag_in;
      len_ff  <= len_in;
      tdig_ff <= tdig_in;
      lbyt_ff <= lbyt_in;
      hlen_ff <= hlen_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   assign sts.err       = FIELD_W'(tag_ff) > max_ff;
   assign sts.tag_small = tag_small;
   assign sts.len_short = len_short;
   assign sts.idx_zero  = (idx_ff == '0);

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* design/bthe_controller.sv */
// Controller: sequences the header octets of one request.
`timescale 1ns / 1ps
module bthe_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bthe_pkg::sts_type sts,
   output bthe_pkg::cmd_type cmd,
   output logic              busy
);
   import bthe_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (start) state_in = ST_PREP;
         ST_PREP:     state_in = sts.err ? ST_ERR : ST_ID_LEAD;
         ST_ERR:      state_in = ST_IDLE;
         ST_ID_LEAD:  state_in = sts.tag_small ? ST_LEN_LEAD : ST_TAG;
         ST_TAG:      if (sts.idx_zero) state_in = ST_LEN_LEAD;
         ST_LEN_LEAD: state_in = sts.len_short ? ST_IDLE : ST_LEN;
         ST_LEN:      if (sts.idx_zero) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.sel = OCT_ERR;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_ERR: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
         end
         ST_ID_LEAD: begin
            cmd.emit         = 1'b1;
            cmd.sel          = OCT_ID_LEAD;
            cmd.idx_load_tag = 1'b1;
         end
         ST_TAG: begin
            cmd.emit    = 1'b1;
            cmd.sel     = OCT_TAG;
            cmd.idx_dec = 1'b1;
         end
         ST_LEN_LEAD: begin
            cmd.emit         = 1'b1;
            cmd.sel          = OCT_LEN_LEAD;
            cmd.last         = sts.len_short;
            cmd.idx_load_len = 1'b1;
         end
         ST_LEN: begin
            cmd.emit    = 1'b1;
            cmd.sel     = OCT_LEN;
            cmd.last    = sts.idx_zero;
            cmd.idx_dec = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* design/ber_tag_length_header_encoder.sv */
// Top level of the BER identifier and length header encoder.
`timescale 1ns / 1ps
// Usage:
//   Request channel: drive req_payload and raise start; the request is taken
//   at a rising edge where start is high and busy is low.
//   Result channel: one header octet per cycle, marked by rsp_strobe, in wire
//   order; last_octet flags the final octet. The receiver cannot stall, so
//   octets leave back to back with no gaps inside one header.
//   A tag above max_tag_number gives one result: octet 0, status 1, length 0.
//   CSR channel: csr_data writes max_tag_number; csr_ready is always high.
//   Write it only while busy is low and no results are pending.
// Sequencing:
//   After the accepting edge the controller passes through a prep state that
//   counts tag digits and length bytes, then emits one octet per state; each
//   octet is registered before it shows. A header holds 2 to 11 octets; busy
//   stays high through the state that emits the last octet, and no new
//   request is taken until busy falls.
// Reset:
//   Synchronous, active high; returns to idle, drops the strobe and sets
//   max_tag_number to its full-range value.
module ber_tag_length_header_encoder #(
   parameter int TAG_BITS = bthe_pkg::TAG_BITS_DEFAULT,
   parameter int LEN_BITS = bthe_pkg::LEN_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  bthe_pkg::req_type            req_payload,
   output logic                         rsp_strobe,
   output bthe_pkg::rsp_type            rsp_payload,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bthe_pkg::FIELD_W-1:0] csr_data
);
   import bthe_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   bthe_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   bthe_datapath #(
      .TAG_BITS (TAG_BITS),
      .LEN_BITS (LEN_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // error result stands alone
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status |->
         rsp_payload.last_octet && (rsp_payload.header_length == '0))
      else $error("error result is not a lone final octet");

   // octets of one header leave without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last_octet |=> rsp_strobe)
      else $error("gap inside a header");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   // length field holds over one header
   a_hlen_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last_octet |=>
         $stable(rsp_payload.header_length))
      else $error("header length changed inside a header");

endmodule

/* dv/tb.sv */
// Testbench for the BER tag and length header encoder: directed and random requests.
`timescale 1ns / 1ps
module tb;
   import bthe_pkg::*;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS  = 42;
   localparam int NUM_PHASES   = 6;

   class header_scoreboard;
      localparam logic STATUS_OK        = 1'b0;
      localparam logic STATUS_TAG_RANGE = 1'b1;

      rsp_type            expected_octets[$];
      logic [FIELD_W-1:0] tag_limit;
      int                 mismatches;

      function new();
         tag_limit  = MAX_TAG_RESET;
         mismatches = 0;
      endfunction

      function void set_limit(logic [FIELD_W-1:0] value);
         tag_limit = value;
      endfunction

      // Encode one header and queue its octets in wire order.
      function void note_request(req_type r);
         logic [7:0]         oct [0:10];
         logic [7:0]         lead;
         logic [FIELD_W-1:0] rest;
         logic [FIELD_W-1:0] piece;
         int                 n;
         int                 digits;
         int                 nbytes;
         int                 i;
         rsp_type            e;
         if (r.tag_number > tag_limit) begin
            e.header_octet  = 8'h00;
            e.last_octet    = 1'b1;
            e.status        = STATUS_TAG_RANGE;
            e.header_length = '0;
            expected_octets.push_back(e);
            return;
         end
         n    = 0;
         lead = {r.tag_class, r.constructed, 5'h00};
         if (r.tag_number < LOW_TAG_LIMIT) begin
            oct[n] = lead | {3'b000, r.tag_number[4:0]};
            n++;
         end else begin
            digits = 1;
            rest   = r.tag_number >> 7;
            while (rest != 0) begin
               digits++;
               rest = rest >> 7;
            end
            oct[n] = lead | {3'b000, ID_ESCAPE};
            n++;
            // base-128, most significant digit first, continuation on all but the last
            for (i = digits - 1; i >= 0; i--) begin
               piece  = r.tag_number >> (7 * i);
               oct[n] = {i != 0, piece[6:0]};
               n++;
            end
         end
         if (r.content_length < SHORT_LEN_LIMIT) begin
            oct[n] = {1'b0, r.content_length[6:0]};
            n++;
         end else begin
            nbytes = 0;
            rest   = r.content_length;
            while (rest != 0) begin
               nbytes++;
               rest = rest >> 8;
            end
            oct[n] = LONG_LEN | 8'(nbytes);
            n++;
            for (i = nbytes - 1; i >= 0; i--) begin
               piece  = r.content_length >> (8 * i);
               oct[n] = piece[7:0];
               n++;
            end
         end
         for (i = 0; i < n; i++) begin
            e.header_octet  = oct[i];
            e.last_octet    = (i == n - 1);
            e.status        = STATUS_OK;
            e.header_length = HLEN_W'(n);
            expected_octets.push_back(e);
         end
      endfunction

      task mismatch(string msg);
         mismatches++;
         $display("mismatch at %0t ns: %s", $time, msg);
      endtask

      task check_octet(rsp_type got);
         rsp_type want;
         if (expected_octets.size() == 0) begin
            mismatch($sformatf("octet %02h arrived with nothing pending", got.header_octet));
            return;
         end
         want = expected_octets.pop_front();
         if (got.header_octet !== want.header_octet)
            mismatch($sformatf("header_octet %02h, want %02h",
                               got.header_octet, want.header_octet));
         if (got.last_octet !== want.last_octet)
            mismatch($sformatf("last_octet %b, want %b", got.last_octet, want.last_octet));
         if (got.status !== want.status)
            mismatch($sformatf("status %b, want %b", got.status, want.status));
         if (got.header_length !== want.header_length)
            mismatch($sformatf("header_length %0d, want %0d",
                               got.header_length, want.header_length));
      endtask
   endclass

   logic               clock;
   logic               reset       = 1'b1;
   logic               start       = 1'b0;
   logic               busy;
   req_type            req_payload = '0;
   logic               rsp_strobe;
   rsp_type            rsp_payload;
   logic               csr_valid   = 1'b0;
   logic               csr_ready;
   logic [FIELD_W-1:0] csr_data    = '0;
   logic [FIELD_W-1:0] tag_ceiling = MAX_TAG_RESET;
   int unsigned        cycles      = 0;
   header_scoreboard   ledger      = new();

   ber_tag_length_header_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            ledger.set_limit(csr_data);
         if (start && !busy)
            ledger.note_request(req_payload);
         if (rsp_strobe)
            ledger.check_octet(rsp_payload);
      end
   end

   function automatic logic [FIELD_W-1:0] spread_value();
      int                 w;
      logic [FIELD_W-1:0] v;
      // random width first, so short and long encodings both show up often
      w = $urandom_range(0, FIELD_W);
      v = FIELD_W'($urandom);
      if (w < FIELD_W)
         v = v & ((FIELD_W'(1) << w) - 1'b1);
      return v;
   endfunction

   function automatic req_type make_request(logic [1:0] cls, logic cons,
                                            logic [FIELD_W-1:0] tag,
                                            logic [FIELD_W-1:0] len);
      req_type r;
      r.tag_class      = cls;
      r.constructed    = cons;
      r.tag_number     = tag;
      r.content_length = len;
      return r;
   endfunction

   function automatic req_type random_request(logic [FIELD_W-1:0] limit);
      req_type r;
      r = make_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       spread_value(), spread_value());
      // probe the limit boundary now and then
      if ($urandom_range(0, 5) == 0)
         r.tag_number = limit + FIELD_W'($urandom_range(0, 1));
      return r;
   endfunction

   task send_request(req_type r);
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
   endtask

   task idle_gap(int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Hold off until the encoder is idle and every octet has been seen.
   task wait_drain();
      @(negedge clock);
      start <= 1'b0;
      while (ledger.expected_octets.size() != 0 || busy) @(negedge clock);
   endtask

   task write_limit(logic [FIELD_W-1:0] value);
      wait_drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid   <= 1'b0;
      tag_ceiling  = value;
   endtask

   initial begin
      logic [FIELD_W-1:0] phase_limits [NUM_PHASES];
      int                 sent;
      int                 burst;
      int                 gap;
      int                 p;
      bit                 steady;
      phase_limits = '{MAX_TAG_RESET, spread_value(), '0, 31'd31, 31'd16383, MAX_TAG_RESET};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tag and length boundaries at the reset limit
      send_request(make_request(2'd0, 1'b0, 31'd0, 31'd0));
      send_request(make_request(2'd3, 1'b1, 31'd30, 31'd127));
      send_request(make_request(2'd1, 1'b0, 31'd31, 31'd128));
      send_request(make_request(2'd2, 1'b1, 31'd127, 31'd255));
      send_request(make_request(2'd0, 1'b1, 31'd128, 31'd256));
      send_request(make_request(2'd3, 1'b0, 31'd16383, 31'd65535));
      send_request(make_request(2'd1, 1'b1, 31'd16384, 31'd65536));
      send_request(make_request(2'd2, 1'b0, 31'h001F_FFFF, 31'h00FF_FFFF));
      send_request(make_request(2'd0, 1'b0, 31'h0020_0000, 31'h0100_0000));
      send_request(make_request(2'd1, 1'b0, 31'h0FFF_FFFF, 31'h0));
      send_request(make_request(2'd2, 1'b1, 31'h1000_0000, 31'h1));
      send_request(make_request(2'd3, 1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF));

      // tags at and just above the limit, at limit 0 and at limit 30
      write_limit('0);
      send_request(make_request(2'd0, 1'b0, 31'd0, 31'd5));
      send_request(make_request(2'd1, 1'b1, 31'd1, 31'd5));
      send_request(make_request(2'd3, 1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
      write_limit(31'd30);
      send_request(make_request(2'd2, 1'b0, 31'd30, 31'd200));
      send_request(make_request(2'd2, 1'b1, 31'd31, 31'd200));

      for (p = 0; p < NUM_PHASES; p++) begin
         write_limit(phase_limits[p]);
         steady = (p == NUM_PHASES - 1);
         sent   = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < PHASE_ITEMS) begin
               send_request(random_request(tag_ceiling));
               sent++;
               burst--;
            end
            if (!steady) begin
               gap = $urandom_range(0, 8);
               if (gap > 0)
                  idle_gap(gap);
               if ($urandom_range(0, 15) == 0)
                  wait_drain();
            end
         end
      end

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.expected_octets.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
